FILE: rtl/snt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sigmoid neuron training unit: shared package
// Item types, operation and register codes, datapath widths and the sigmoid
// lookup table, which is built at elaboration from a fixed-point series.
// ----------------------------------------------------------------------------
package snt_pkg;

  // Sizes of the neuron and the activation table.
  localparam int MAX_INPUTS = 16;
  localparam int SIG_DEPTH  = 256;
  localparam int SIG_IDX_W  = $clog2(SIG_DEPTH);
  localparam int WADDR_W    = $clog2(MAX_INPUTS + 1);

  // Field widths of the items, the accumulator and the configuration port.
  localparam int IDX_W   = 5;
  localparam int VAL_W   = 16;
  localparam int OUT_W   = 13;
  localparam int LR_W    = 13;
  localparam int CNT_W   = 5;
  localparam int ACC_W   = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [WADDR_W-1:0] BIAS_ADDR = WADDR_W'(MAX_INPUTS);
  localparam logic [IDX_W-1:0]   MAX_IDX   = IDX_W'(MAX_INPUTS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT   = 2'd1;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_FORWARD = 2'd1,
    OP_ERROR   = 2'd2,
    OP_UPDATE  = 2'd3
  } op_e;

  typedef enum logic {
    RES_FORWARD = 1'b0,
    RES_UPDATE  = 1'b1
  } res_kind_e;

  typedef struct packed {
    op_e                      operation;
    logic [IDX_W-1:0]         element_index;
    logic signed [VAL_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    res_kind_e                result_kind;
    logic [OUT_W-1:0]         neuron_output;
    logic signed [VAL_W-1:0]  neuron_delta;
  } out_item_t;

  typedef logic [SIG_DEPTH-1:0][OUT_W-1:0] sig_table_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // Shift-and-subtract division, used only while building the table.
  function automatic logic [63:0] udiv48(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    int          i;
    q = '0;
    r = '0;
    for (i = 47; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^(-f) for f in Q0.12 over [0, 1], result in Q2.30.
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int                 k;
    sum  = signed'(Q30_ONE);
    term = Q30_ONE;
    for (k = 1; k <= 16; k++) begin
      term = udiv48(term * f, 64'(4096 * k));
      if ((k % 2) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    return (sum > 0) ? unsigned'(sum) : 64'd0;
  endfunction

  // e^(-x) for x in Q4.12, result in Q2.30: fraction by series, whole part by
  // repeated multiplication with e^(-1).
  function automatic logic [63:0] exp_neg(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] e1;
    logic [63:0] n;
    int          i;
    n  = x >> 12;
    r  = exp_neg_frac(x & 64'd4095);
    e1 = exp_neg_frac(64'd4096);
    for (i = 0; i < 16; i++) begin
      if (64'(i) < n) begin
        r = (r * e1) >> 30;
      end
    end
    return r;
  endfunction

  // Sigmoid of each bin centre, rounded to Q1.12.
  function automatic sig_table_t build_sig_table();
    sig_table_t  tbl;
    int          k;
    int          xc;
    logic [63:0] mag;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] s;
    for (k = 0; k < SIG_DEPTH; k++) begin
      xc  = ((2 * k + 1) * 32768) / SIG_DEPTH - 32768;
      mag = (xc < 0) ? 64'(-xc) : 64'(xc);
      e   = exp_neg(mag);
      den = Q30_ONE + e;
      if (xc >= 0) begin
        s = udiv48((64'd1 << 42) + (den >> 1), den);
      end else begin
        s = udiv48(64'd4096 * e + (den >> 1), den);
      end
      tbl[k] = (s > 64'd4096) ? OUT_W'(4096) : OUT_W'(s);
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

FILE: rtl/snt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module snt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 17
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/snt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier used for every product of the neuron, with the product
// registered.
// ----------------------------------------------------------------------------
module snt_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [snt_pkg::MUL_A_W-1:0]   a_i,
  input  logic signed [snt_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [snt_pkg::MUL_P_W-1:0]   prod_o
);

  import snt_pkg::*;

  logic signed [MUL_P_W-1:0] prod_d;

  // Full-width signed product.
  assign prod_d = MUL_P_W'(a_i) * MUL_P_W'(b_i);

  // Product register, loaded only when an operation is issued.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= prod_d;
    end
  end

endmodule

FILE: rtl/sigmoid_neuron_train_unit.sv
`timescale 1ns / 1ps
// Sequencing: a weight write is done at acceptance; a set-error item runs through S_EMUL1,
// S_EMUL2 and S_EDONE; a forward element through S_FRD and S_FACC, the last one also
// through S_FACT and S_EMIT; an update element through S_USTEP, S_UMUL and S_UWR, the last
// one also through S_UBIAS and S_EMIT. A full output register adds stalls in S_EMIT.
// Throughput: one item at a time; a new item is accepted only in the idle state, and all
// products share the one multiplier. Reset clears control state, the accumulator, output
// and delta registers, and loads the learning rate and input count defaults.
// Sigmoid neuron training unit
// One sigmoid neuron with a bias, forward pass through a lookup table and
// delta-rule weight updates, all sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
module sigmoid_neuron_train_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  snt_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output snt_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [snt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [snt_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import snt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EMUL1 = 4'd1;
  localparam logic [3:0] S_EMUL2 = 4'd2;
  localparam logic [3:0] S_EDONE = 4'd3;
  localparam logic [3:0] S_FRD   = 4'd4;
  localparam logic [3:0] S_FACC  = 4'd5;
  localparam logic [3:0] S_FACT  = 4'd6;
  localparam logic [3:0] S_USTEP = 4'd7;
  localparam logic [3:0] S_UMUL  = 4'd8;
  localparam logic [3:0] S_UWR   = 4'd9;
  localparam logic [3:0] S_UBIAS = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0] state_q, state_d;

  // Configuration registers.
  logic [LR_W-1:0]  lr_q;
  logic [CNT_W-1:0] cnt_q;

  // Item registers.
  logic [IDX_W-1:0]        idx_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    first_q, last_q;

  // Neuron state.
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [OUT_W-1:0]        out_q, out_d;
  logic signed [VAL_W-1:0] delta_q, delta_d;
  logic signed [28:0]      step_q;
  res_kind_e               kind_q, kind_d;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;
  logic      out_load;

  // Weight store and multiplier connections.
  logic                      ram_we, ram_re;
  logic [WADDR_W-1:0]        ram_waddr, ram_raddr;
  logic signed [VAL_W-1:0]   ram_wdata, ram_rdata;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic             in_acc;
  logic [CNT_W-1:0] n_eff;
  logic [LR_W-1:0]  lr_eff;
  logic             elem_ok;

  // Rounding and saturation helpers.
  logic signed [MUL_P_W:0]   p_rnd24;
  logic signed [23:0]        p_q24;
  logic signed [29:0]        step_rnd;
  logic signed [17:0]        bias_step;
  logic signed [ACC_W:0]     acc_rnd;
  logic signed [ACC_W:0]     fwd_base, fwd_sum;
  logic signed [VAL_W-1:0]   act_sat;
  logic [VAL_W-1:0]          act_biased;

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [31:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  snt_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_INPUTS + 1)
  ) u_weights (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  snt_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(mul_p)
  );

  // Effective configuration with out-of-range values clamped.
  assign n_eff  = (cnt_q == '0) ? CNT_W'(1) : ((cnt_q > MAX_IDX) ? MAX_IDX : cnt_q);
  assign lr_eff = (lr_q > LR_W'(4096)) ? LR_W'(4096) : lr_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign elem_ok     = (in_data_i.element_index < n_eff);
  assign cfg_ready_o = 1'b1;

  // Round half up of the product at bit 24, and of the step at bit 12.
  assign p_rnd24   = (MUL_P_W + 1)'(mul_p) + (MUL_P_W + 1)'(25'sd8388608);
  assign p_q24     = p_rnd24[47:24];
  assign step_rnd  = 30'(step_q) + 30'sd2048;
  assign bias_step = step_rnd[29:12];

  // Activation: accumulator rounded to Q4.12, saturated, offset for the table.
  assign acc_rnd    = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(13'sd2048);
  assign act_sat    = sat16(32'(signed'(acc_rnd[ACC_W:12])));
  assign act_biased = act_sat ^ 16'h8000;

  // Forward accumulation: element zero restarts from the bias.
  assign fwd_base = first_q ? (ACC_W + 1)'(signed'({ram_rdata, 12'b0}))
                            : (ACC_W + 1)'(acc_q);
  assign fwd_sum  = fwd_base + (ACC_W + 1)'(signed'(mul_p[31:0]));

  // Sequencer, datapath control and next-state logic.
  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    out_d     = out_q;
    delta_d   = delta_q;
    kind_d    = kind_q;
    ram_we    = 1'b0;
    ram_waddr = in_data_i.element_index;
    ram_wdata = in_data_i.value;
    ram_re    = 1'b0;
    ram_raddr = in_data_i.element_index;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.operation)
            OP_WRITE: begin
              ram_we = (in_data_i.element_index <= MAX_IDX);
            end
            OP_ERROR: begin
              state_d = S_EMUL1;
            end
            OP_FORWARD: begin
              if (elem_ok) begin
                ram_re  = 1'b1;
                state_d = S_FRD;
              end
            end
            OP_UPDATE: begin
              if (elem_ok) begin
                ram_re  = 1'b1;
                state_d = S_USTEP;
              end
            end
            default: ;
          endcase
        end
      end
      // Error: out*(1-out), then times the error.
      S_EMUL1: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(signed'({1'b0, out_q}));
        mul_b   = 17'sd4096 - MUL_B_W'(signed'({1'b0, out_q}));
        state_d = S_EMUL2;
      end
      S_EMUL2: begin
        mul_en  = 1'b1;
        mul_a   = mul_p[MUL_A_W-1:0];
        mul_b   = MUL_B_W'(val_q);
        state_d = S_EDONE;
      end
      S_EDONE: begin
        delta_d = sat16(32'(p_q24));
        state_d = S_IDLE;
      end
      // Forward: weight times input, while the bias is fetched for the sum.
      S_FRD: begin
        mul_en    = 1'b1;
        mul_a     = MUL_A_W'(ram_rdata);
        mul_b     = MUL_B_W'(val_q);
        ram_re    = 1'b1;
        ram_raddr = BIAS_ADDR;
        state_d   = S_FACC;
      end
      S_FACC: begin
        if (fwd_sum[ACC_W] != fwd_sum[ACC_W-1]) begin
          acc_d = fwd_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
          acc_d = fwd_sum[ACC_W-1:0];
        end
        state_d = last_q ? S_FACT : S_IDLE;
      end
      S_FACT: begin
        out_d   = SIG_TABLE[act_biased[VAL_W-1 -: SIG_IDX_W]];
        kind_d  = RES_FORWARD;
        state_d = S_EMIT;
      end
      // Update: step = lr*delta, then step times the input.
      S_USTEP: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(signed'({1'b0, lr_eff}));
        mul_b   = MUL_B_W'(delta_q);
        state_d = S_UMUL;
      end
      S_UMUL: begin
        mul_en  = 1'b1;
        mul_a   = mul_p[MUL_A_W-1:0];
        mul_b   = MUL_B_W'(val_q);
        state_d = S_UWR;
      end
      S_UWR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = sat16(32'(ram_rdata) + 32'(p_q24));
        if (last_q) begin
          ram_re    = 1'b1;
          ram_raddr = BIAS_ADDR;
          state_d   = S_UBIAS;
        end else begin
          state_d   = S_IDLE;
        end
      end
      S_UBIAS: begin
        ram_we    = 1'b1;
        ram_waddr = BIAS_ADDR;
        ram_wdata = sat16(32'(ram_rdata) + 32'(bias_step));
        kind_d    = RES_UPDATE;
        state_d   = S_EMIT;
      end
      // Hand the result to the output register once it is free.
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and neuron state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      out_q       <= '0;
      delta_q     <= '0;
      kind_q      <= RES_FORWARD;
      lr_q        <= LR_W'(410);
      cnt_q       <= CNT_W'(16);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      out_q       <= out_d;
      delta_q     <= delta_d;
      kind_q      <= kind_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_LEARNING_RATE) begin
          lr_q <= cfg_data_i[LR_W-1:0];
        end else if (cfg_index_i == CFG_INPUT_COUNT) begin
          cnt_q <= cfg_data_i[CNT_W-1:0];
        end
      end
    end
  end

  // Item fields captured at acceptance, step kept for the bias update, result loaded on hand-over.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q   <= in_data_i.element_index;
      val_q   <= in_data_i.value;
      first_q <= (in_data_i.element_index == '0);
      last_q  <= (in_data_i.element_index == (n_eff - CNT_W'(1)));
    end
    if (state_q == S_UMUL) begin
      step_q <= mul_p[28:0];
    end
    if (out_load) begin
      out_data_q.result_kind   <= kind_q;
      out_data_q.neuron_output <= out_q;
      out_data_q.neuron_delta  <= delta_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The weight store never reads and writes one entry in the same cycle.
  a_ram_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("weight store read and write collide");

  // A result waiting on a free output register leaves the emit state at once.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !out_valid_q) |=> (state_q == S_IDLE))
    else $error("result not handed over to a free output register");

  // The delta register changes only at the end of an error item.
  a_delta_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(delta_q) |-> ($past(state_q) == S_EDONE))
    else $error("delta changed outside an error item");

  // The activation is looked up only after the last forward element.
  a_fact_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FACT) |-> (last_q && $past(state_q) == S_FACC))
    else $error("activation looked up before the last element");

endmodule
